// ----- rtl/deq_pkg.sv -----
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_FRONT      = 3'd6,
        CMD_BACK       = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// ----- rtl/deq_cell.sv -----
// One storage cell of the rotating ring: take the neighbor's word or a new word.
module deq_cell #(
    parameter int W = deq_pkg::DATA_W
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_shift_data,
    input  logic         i_load,
    input  logic [W-1:0] i_load_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = i_load ? i_load_data : i_shift_data;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/deq_ring.sv -----
// Ring of cells that rotates by one cell every cycle, with its phase counter.
module deq_ring #(
    parameter int DEPTH = deq_pkg::DEPTH,
    parameter int W     = deq_pkg::DATA_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [W-1:0]             i_wr_data,
    output logic [$clog2(DEPTH)-1:0] o_phase,
    output logic [W-1:0]             o_tap
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [W-1:0]     w_cell [DEPTH];
    logic [PTR_W-1:0] r_phase;
    logic [PTR_W-1:0] n_phase;

    // Cell i hands its word to cell i-1; cell 0 wraps to the last cell.
    // The word at cell 0 lands in the last cell, so a write to the slot
    // now at the tap goes into the last cell.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        deq_cell #(
            .W (W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_shift_data (w_cell[(g + 1) % DEPTH]),
            .i_load       (i_wr_en && (g == DEPTH - 1)),
            .i_load_data  (i_wr_data),
            .o_data       (w_cell[g])
        );
    end

    // Phase is the ring slot that sits in cell 0.
    always_comb begin
        n_phase = (r_phase == LAST) ? '0 : r_phase + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;
    assign o_tap   = w_cell[0];

endmodule

// ----- rtl/double_ended_queue.sv -----
// Top level of the double-ended queue built on a rotating ring of cells.
//
//  channel | ports                                  | moves
//  --------+----------------------------------------+-------------------------------
//  in      | i_valid, o_ready, i_cmd, i_value       | one command item
//  out     | o_valid, i_ready, o_data, o_status     | one result item (none for a stored push)
//
// Commands that need no stored word (size, empty, a push into a full queue, a
// pop or peek on an empty queue) go from accept to the done state and on to
// the output register. Store commands wait in the seek state: the ring turns
// one cell per cycle and the target slot must reach the tap at cell 0.
// Reset (i_rst_n low at a clock edge) empties the queue; stored words keep
// whatever they held. A stall on the output holds the finished result in the
// output register while the next item is already taken; a second result then
// waits in the done state until the output register frees up.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_cmd,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [deq_pkg::DATA_W-1:0] o_data,
    output logic [1:0]                        o_status
);

    localparam int W     = deq_pkg::DATA_W;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X   = (CNT_W + 1)'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEEK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Control state
    t_state           r_state;
    t_state           n_state;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;

    // Payload of the item in flight and of the result
    deq_pkg::t_cmd    r_cmd;
    deq_pkg::t_cmd    n_cmd;
    logic [W-1:0]     r_val;
    logic [W-1:0]     n_val;
    logic [PTR_W-1:0] r_target;
    logic [PTR_W-1:0] n_target;
    logic [W-1:0]     r_res_data;
    logic [W-1:0]     n_res_data;
    deq_pkg::t_status r_res_status;
    deq_pkg::t_status n_res_status;
    logic [W-1:0]     r_out_data;
    logic [W-1:0]     n_out_data;
    deq_pkg::t_status r_out_status;
    deq_pkg::t_status n_out_status;

    // Ring pointer arithmetic
    logic [PTR_W-1:0] w_head_m1;
    logic [PTR_W-1:0] w_head_p1;
    logic [CNT_W:0]   w_tail_sum;
    logic [CNT_W:0]   w_back_sum;
    logic [PTR_W-1:0] w_tail_slot;
    logic [PTR_W-1:0] w_back_slot;
    logic             w_full;
    logic             w_empty;

    // Ring interface
    logic             w_accept;
    logic             w_hit;
    logic             w_wr_en;
    logic [PTR_W-1:0] w_phase;
    logic [W-1:0]     w_tap;

    deq_pkg::t_cmd    w_in_cmd;

    deq_ring #(
        .DEPTH (DEPTH),
        .W     (W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (r_val),
        .o_phase   (w_phase),
        .o_tap     (w_tap)
    );

    assign w_in_cmd = deq_pkg::t_cmd'(i_cmd);
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_hit    = (r_state == S_SEEK) && (w_phase == r_target);
    // Pushes write the slot as it passes the tap.
    assign w_wr_en  = w_hit && ((r_cmd == deq_pkg::CMD_PUSH_FRONT) ||
                                (r_cmd == deq_pkg::CMD_PUSH_BACK));

    // Slot arithmetic modulo DEPTH; head < DEPTH and count <= DEPTH keep
    // every sum below twice DEPTH, so one conditional subtract wraps it.
    always_comb begin
        w_head_m1   = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
        w_head_p1   = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
        w_tail_sum  = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count);
        if (w_tail_sum >= DEPTH_X) begin
            w_tail_sum = w_tail_sum - DEPTH_X;
        end
        // Back slot only matters when the queue holds something.
        w_back_sum  = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count) - 1'b1;
        if (w_back_sum >= DEPTH_X) begin
            w_back_sum = w_back_sum - DEPTH_X;
        end
        w_tail_slot = w_tail_sum[PTR_W-1:0];
        w_back_slot = w_back_sum[PTR_W-1:0];
        w_full      = (r_count == FULL_CNT);
        w_empty     = (r_count == '0);
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_target     = r_target;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;

        // Drop the shown result once it is taken.
        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = w_in_cmd;
                    n_val        = i_value;
                    n_res_status = deq_pkg::ST_OK;
                    n_res_data   = '0;
                    case (w_in_cmd) inside
                        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                            if (w_full) begin
                                // Drop the word and report a full queue.
                                n_res_status = deq_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_target = (w_in_cmd == deq_pkg::CMD_PUSH_FRONT) ?
                                           w_head_m1 : w_tail_slot;
                                n_state  = S_SEEK;
                            end
                        end
                        deq_pkg::CMD_SIZE: begin
                            n_res_data = W'(r_count);
                            n_state    = S_DONE;
                        end
                        deq_pkg::CMD_EMPTY: begin
                            n_res_data = W'(w_empty);
                            n_state    = S_DONE;
                        end
                        default: begin
                            // Pops and peeks
                            if (w_empty) begin
                                n_res_data   = '1;
                                n_res_status = deq_pkg::ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_target = ((w_in_cmd == deq_pkg::CMD_POP_FRONT) ||
                                            (w_in_cmd == deq_pkg::CMD_FRONT)) ?
                                           r_head : w_back_slot;
                                n_state  = S_SEEK;
                            end
                        end
                    endcase
                end
            end
            S_SEEK: begin
                // Wait for the target slot to turn to the tap, then act.
                if (w_hit) begin
                    n_res_data = w_tap;
                    n_state    = S_DONE;
                    case (r_cmd) inside
                        deq_pkg::CMD_PUSH_FRONT: begin
                            n_head  = w_head_m1;
                            n_count = r_count + 1'b1;
                            n_state = S_IDLE;
                        end
                        deq_pkg::CMD_PUSH_BACK: begin
                            n_count = r_count + 1'b1;
                            n_state = S_IDLE;
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            n_head  = w_head_p1;
                            n_count = r_count - 1'b1;
                        end
                        deq_pkg::CMD_POP_BACK: begin
                            n_count = r_count - 1'b1;
                        end
                        default: begin
                            // Peeks leave the queue as it is.
                        end
                    endcase
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_val        <= n_val;
        r_target     <= n_target;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_status = r_out_status;

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// Self-checking testbench for the double-ended queue: directed table, random traffic, full fill.
`timescale 1ns / 100ps

module double_ended_queue_tb;

    localparam int DATA_W = deq_pkg::DATA_W;
    localparam int DEPTH  = deq_pkg::DEPTH;

    // Run sizing. Store accesses wait for the ring to bring their slot to
    // the tap, so the receiver hold-off and watchdog both scale from DEPTH.
    localparam int TOTAL_ITEMS    = 1900;
    localparam int MIXED_ITEMS    = 350;
    localparam int FULL_EXTRA     = 6;
    localparam int PRESSURE_HOLD  = 3 * DEPTH;
    localparam int HOLD_AT_FIRST  = 40;
    localparam int HOLD_AT_SECOND = 700;
    localparam int SETTLE_CYCLES  = DEPTH + 32;
    localparam int WATCHDOG_LIMIT = 4 * (PRESSURE_HOLD + DEPTH + 32);
    localparam int N_DIRECTED     = 25;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        deq_pkg::t_status  status;
    } t_deq_result;

    // One row of the directed table. Where known_result is set, the
    // expected data and status come from the row, not from the mirror.
    typedef struct packed {
        deq_pkg::t_cmd     cmd;
        logic [DATA_W-1:0] value;
        bit                known_result;
        logic [DATA_W-1:0] data;
        deq_pkg::t_status  status;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [2:0]               i_cmd;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [DATA_W-1:0] o_data;
    logic [1:0]               o_status;

    double_ended_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data),
        .o_status (o_status)
    );

    // Mirror of the queue contents: ring store, front index and occupancy.
    logic [DATA_W-1:0] mirror_mem [DEPTH];
    int                mirror_head;
    int                mirror_count;

    // Results still owed by the block, oldest first.
    t_deq_result pending_results [$];

    t_dir_row directed_rows [N_DIRECTED];

    int n_errors;
    int n_items;
    int n_results;
    int n_full_drops;
    int n_empty_hits;
    int n_wraps;
    int max_fill;
    int idle_cycles;
    int n_cycles;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Apply one command to the mirror and work out the result it owes.
    function automatic void deque_apply(input deq_pkg::t_cmd cmd,
                                        input logic [DATA_W-1:0] value,
                                        output bit has_result, output t_deq_result res);
        has_result = 1'b1;
        res.data   = '0;
        res.status = deq_pkg::ST_OK;
        case (cmd) inside
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                if (mirror_count >= DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    has_result = 1'b0;
                    if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
                        mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                        mirror_mem[mirror_head] = value;
                    end else begin
                        mirror_mem[(mirror_head + mirror_count) % DEPTH] = value;
                    end
                    mirror_count++;
                end
            end
            deq_pkg::CMD_SIZE: begin
                res.data = mirror_count;
            end
            deq_pkg::CMD_EMPTY: begin
                res.data = (mirror_count == 0) ? 1 : 0;
            end
            default: begin
                if (mirror_count == 0) begin
                    res.data   = '1;
                    res.status = deq_pkg::ST_EMPTY;
                end else if (cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_FRONT) begin
                    res.data = mirror_mem[mirror_head];
                    if (cmd == deq_pkg::CMD_POP_FRONT) begin
                        mirror_head = (mirror_head + 1) % DEPTH;
                        mirror_count--;
                    end
                end else begin
                    res.data = mirror_mem[(mirror_head + mirror_count - 1) % DEPTH];
                    if (cmd == deq_pkg::CMD_POP_BACK) begin
                        mirror_count--;
                    end
                end
            end
        endcase
    endfunction

    // Draw the idle cycles before the next item. Now and then start a
    // stretch of back-to-back items with no idling at all.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Pick a random command; the rest after pushes and pops goes to
    // size, empty and the two peeks.
    function automatic deq_pkg::t_cmd pick_cmd(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        end
        if (roll < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
        end
        case ($urandom_range(0, 3))
            0:       return deq_pkg::CMD_SIZE;
            1:       return deq_pkg::CMD_EMPTY;
            2:       return deq_pkg::CMD_FRONT;
            default: return deq_pkg::CMD_BACK;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %h, expected %h (result %0d)",
                 $time, what, got, want, n_results);
    endtask

    // Offer one item, hold it until the block takes it, then update the
    // mirror. Enter and leave just after a falling edge.
    int send_burst_left;

    task automatic send_cmd(input deq_pkg::t_cmd cmd, input logic [DATA_W-1:0] value,
                            input bit known_result, input t_deq_result known);
        int          gap;
        bit          has_result;
        t_deq_result res;
        gap = draw_gap(send_burst_left);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Accepted at this edge: advance the mirror and queue the result.
        if ((cmd == deq_pkg::CMD_PUSH_FRONT && mirror_head == 0) ||
            (cmd == deq_pkg::CMD_PUSH_BACK && mirror_head + mirror_count >= DEPTH)) begin
            n_wraps++;
        end
        deque_apply(cmd, value, has_result, res);
        n_items++;
        if (has_result) begin
            if (known_result) begin
                res = known;
            end
            if (res.status == deq_pkg::ST_FULL) n_full_drops++;
            if (res.status == deq_pkg::ST_EMPTY) n_empty_hits++;
            pending_results.insert(pending_results.size(), res);
        end
        if (mirror_count > max_fill) max_fill = mirror_count;
        @(negedge i_clk);
    endtask

    task automatic send_random(input deq_pkg::t_cmd cmd);
        send_cmd(cmd, $urandom, 1'b0, '0);
    endtask

    // Check every result the block hands over, and keep the watchdog fed.
    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n) begin
            n_cycles++;
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (o_valid && i_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_data, '0);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (o_data !== want.data) begin
                        report_mismatch("data", o_data, want.data);
                    end
                    if (o_status !== want.status) begin
                        report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] timeout: no handshake for %0d cycles, %0d results pending",
                         $time, idle_cycles, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Result side: stall at random, and twice hold off for a long stretch
    // so the block backs up and drops its ready.
    initial begin : result_sink
        int stall;
        int burst_left;
        int holds_done;
        burst_left = 0;
        holds_done = 0;
        i_ready    = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ((holds_done == 0 && n_results >= HOLD_AT_FIRST) ||
                (holds_done == 1 && n_results >= HOLD_AT_SECOND)) begin
                stall = PRESSURE_HOLD;
                holds_done++;
            end else begin
                stall = draw_gap(burst_left);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int target;
        directed_rows = '{
            // Fresh queue: size, empty flag and every read on empty.
            '{deq_pkg::CMD_SIZE,       32'h0000_0000, 1'b1, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_EMPTY,      32'hFFFF_FFFF, 1'b1, 32'd1,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_FRONT,  32'h1234_5678, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY},
            '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY},
            '{deq_pkg::CMD_FRONT,      32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY},
            '{deq_pkg::CMD_BACK,       32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY},
            // Push front from head 0 wraps the head to the top slot.
            '{deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_FRONT,      32'h0000_0000, 1'b1, 32'h8000_0000, deq_pkg::ST_OK},
            '{deq_pkg::CMD_BACK,       32'h0000_0000, 1'b1, 32'h7FFF_FFFF, deq_pkg::ST_OK},
            '{deq_pkg::CMD_SIZE,       32'h0000_0000, 1'b1, 32'd2,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_EMPTY,      32'h0000_0000, 1'b1, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_PUSH_BACK,  32'h0000_0000, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_PUSH_BACK,  32'h5A5A_A5A5, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000, deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_BACK,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, 32'h8000_0000, deq_pkg::ST_OK},
            // Drained again: reads on empty after the ring has moved.
            '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY},
            '{deq_pkg::CMD_EMPTY,      32'h0000_0000, 1'b1, 32'd1,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_PUSH_BACK,  32'h0000_0001, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_BACK,       32'h0000_0000, 1'b0, 32'd0,         deq_pkg::ST_OK},
            '{deq_pkg::CMD_POP_FRONT,  32'h0000_0000, 1'b0, 32'd0,         deq_pkg::ST_OK}
        };
        n_errors        = 0;
        n_items         = 0;
        n_results       = 0;
        n_full_drops    = 0;
        n_empty_hits    = 0;
        n_wraps         = 0;
        max_fill        = 0;
        idle_cycles     = 0;
        n_cycles        = 0;
        send_burst_left = 0;
        mirror_head     = 0;
        mirror_count    = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_cmd           = deq_pkg::CMD_SIZE;
        i_value         = '0;

        // Hold reset, then release it at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].cmd, directed_rows[k].value,
                     directed_rows[k].known_result,
                     '{data: directed_rows[k].data, status: directed_rows[k].status});
        end

        // Mixed traffic around a shallow queue: empty reads happen often.
        repeat (MIXED_ITEMS) send_random(pick_cmd(45, 25));

        // Fill to the brim from both ends, with a few queries mixed in,
        // then push into the full queue and look at both ends.
        while (mirror_count < DEPTH) begin
            if ($urandom_range(0, 9) == 0) begin
                send_random(pick_cmd(0, 0));
            end else begin
                send_random($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK :
                                                   deq_pkg::CMD_PUSH_FRONT);
            end
        end
        repeat (FULL_EXTRA) begin
            send_random($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK :
                                               deq_pkg::CMD_PUSH_FRONT);
        end
        send_random(deq_pkg::CMD_SIZE);
        send_random(deq_pkg::CMD_FRONT);
        send_random(deq_pkg::CMD_BACK);

        // Pop-heavy traffic for the rest of the run; pushes near the top
        // may hit the full queue again.
        target = TOTAL_ITEMS;
        while (n_items < target) send_random(pick_cmd(20, 55));
        i_valid <= 1'b0;

        // Wait for every owed result, then let stray results show up.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands over %0d cycles, checked %0d results.",
                 n_items, n_cycles, n_results);
        $display("Peak fill %0d of %0d, %0d pushes dropped when full, %0d empty reads, %0d wraps.",
                 max_fill, DEPTH, n_full_drops, n_empty_hits, n_wraps);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- double_ended_queue.f -----
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_ring.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
